### sv/lifr_pkg.sv
// lifr_pkg: shared types and constants of the linear interpolation frame resampler.
// Holds the input and result beat structs, item kinds, field widths, register indexes and reset values.
// No dependencies.
`default_nettype none

package lifr_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int INDEX_W   = 13;
  localparam int TOTAL_W   = 13;
  localparam int RATE_W    = 17;
  localparam int CHAN_W    = 2;
  localparam int FRAC_W    = 16;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_RATE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_RATE = 2'd2;

  // item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // register reset values
  localparam logic [CHAN_W-1:0] RST_CHANNELS    = 2'd2;
  localparam logic [RATE_W-1:0] RST_SOURCE_RATE = 17'd44100;
  localparam logic [RATE_W-1:0] RST_TARGET_RATE = 17'd48000;

  typedef struct packed {
    logic                       kind;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                       last_frame;
    logic [INDEX_W-1:0]         read_index;
  } in_item_t;

  typedef struct packed {
    logic [TOTAL_W-1:0]         sample_total;
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic                       index_ok;
  } out_item_t;

endpackage

`default_nettype wire

### sv/linear_interp_frame_resampler_top.sv
// linear_interp_frame_resampler_top: frame store, shared bit-serial divider and lerp datapath.
// Depends on lifr_pkg (beat structs, widths, register indexes, reset values).
//
// A load beat or a flagged read gets its result strobe in the next cycle; a last load with a
// nonzero setup first runs the divider. Reads with equal rates or one output frame pass the
// read, multiply and add states; other reads first run the restoring divider, one quotient bit
// a cycle over DVW = 29 + clog2(MAX_INPUT_FRAMES) = 40 bits at defaults. One item in flight at
// a time; busy falls with the strobe, so the next start is accepted at the edge that ends it.
// Reset (rst_n low, synchronous) empties the frame count, closes the block and loads
// stereo, 44100 Hz in, 48000 Hz out. The frame store needs no clearing pass.
// Results are strobed for one cycle; the receiver cannot stall them.
`default_nettype none

module linear_interp_frame_resampler_top #(
  parameter int MAX_INPUT_FRAMES = 2048,
  parameter int OUT_SAMPLE_CAP   = 6144
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input beats
  input  wire logic                              start,
  output logic                                   busy,
  input  wire lifr_pkg::in_item_t                in_data,
  // result beats
  output logic                                   out_valid,
  output lifr_pkg::out_item_t                    out_data,
  // configuration writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [lifr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lifr_pkg::RATE_W-1:0]       cfg_data
);

  localparam int SW   = lifr_pkg::SAMPLE_W;
  localparam int IXW  = lifr_pkg::INDEX_W;
  localparam int TW   = lifr_pkg::TOTAL_W;
  localparam int RW   = lifr_pkg::RATE_W;
  localparam int FW   = lifr_pkg::FRAC_W;
  localparam int AW   = $clog2(MAX_INPUT_FRAMES);        // store address
  localparam int LW   = $clog2(MAX_INPUT_FRAMES + 1);    // loaded frame count
  localparam int OW   = $clog2(OUT_SAMPLE_CAP + 1);      // output frame count
  localparam int CLW  = LW + RW;                         // close dividend
  localparam int RPW  = IXW + AW;                        // index * (frames - 1)
  localparam int RDW  = RPW + FW;                        // read dividend
  localparam int DVW  = (RDW > CLW) ? RDW : CLW;         // divider dividend/quotient
  localparam int DSW  = (OW > RW) ? OW : RW;             // divisor / remainder
  localparam int CNW  = $clog2(DVW + 1);
  localparam int PIW  = DVW - FW;                        // integer part of position
  localparam int CW0  = (OW > IXW) ? OW : IXW;
  localparam int CW   = (LW > CW0) ? LW : CW0;           // common compare width

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_POS, S_RD, S_MUL, S_ADD} state_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [lifr_pkg::CHAN_W-1:0] ch_r;
  logic [RW-1:0]               src_r;
  logic [RW-1:0]               tgt_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r  <= lifr_pkg::RST_CHANNELS;
      src_r <= lifr_pkg::RST_SOURCE_RATE;
      tgt_r <= lifr_pkg::RST_TARGET_RATE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lifr_pkg::CFG_CHANNELS:    ch_r  <= cfg_data[lifr_pkg::CHAN_W-1:0];
        lifr_pkg::CFG_SOURCE_RATE: src_r <= cfg_data;
        lifr_pkg::CFG_TARGET_RATE: tgt_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Control and datapath registers
  // ---------------------------------------------------------------------------
  state_t              state_r;
  logic                out_valid_r;
  lifr_pkg::out_item_t out_data_r;
  logic [LW-1:0]       loaded_r;
  logic [OW-1:0]       out_frames_r;
  logic                block_open_r;
  logic                op_close_r;     // divider result closes a block (else read position)
  logic [DVW-1:0]      quo_r;          // dividend shifts out, quotient shifts in
  logic [DSW-1:0]      rem_r;
  logic [DSW-1:0]      div_r;
  logic [CNW-1:0]      cnt_r;
  logic [AW-1:0]       addr_a_r;
  logic [AW-1:0]       addr_b_r;
  logic [FW-1:0]       frac_r;
  logic [2*SW-1:0]     rd_a_r;
  logic [2*SW-1:0]     rd_b_r;
  logic signed [SW-1:0]   a_l_r;
  logic signed [SW-1:0]   a_r_r;
  logic signed [2*SW+1:0] prod_l_r;
  logic signed [2*SW+1:0] prod_r_r;

  // frame store: right sample in the high half, left in the low half
  logic [2*SW-1:0] frame_mem [MAX_INPUT_FRAMES];

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  function automatic logic [TW-1:0] total_of(input logic [OW-1:0] frames,
                                            input logic [1:0]    chans);
    logic [OW:0] tot;
    begin
      case (chans)
        2'd1:    tot = {1'b0, frames};
        2'd2:    tot = {frames, 1'b0};
        default: tot = '0;
      endcase
      total_of = TW'(tot);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Next-value logic
  // ---------------------------------------------------------------------------
  logic [1:0]      ch_eff;
  logic            accept;
  logic [LW-1:0]   base;
  logic            room;
  logic [LW-1:0]   loaded_nxt;
  logic [OW-1:0]   out_frames_nxt;
  logic            mem_we;
  logic [2*SW-1:0] wr_word;
  logic            close_zero;
  logic [CLW-1:0]  cprod;
  logic [DVW-1:0]  close_dvd;
  logic [IXW-1:0]  rd_idx;
  logic            rd_ok;
  logic [AW-1:0]   frames_m1;
  logic [AW-1:0]   eq_first;
  logic [AW-1:0]   one_second;
  logic [RPW-1:0]  rprod;
  logic [DVW-1:0]  read_dvd;
  logic [DSW:0]    shifted;
  logic [DSW:0]    trial;
  logic            q_bit;
  logic [DVW-1:0]  clamp_n;
  logic [OW-1:0]   clamp_frames;
  logic [PIW-1:0]  pos_int;
  logic [AW-1:0]   pos_first;
  logic [AW-1:0]   pos_second;
  logic signed [SW:0] diff_l;
  logic signed [SW:0] diff_r;
  logic signed [SW:0] frac_s;
  logic [SW:0]     sum_l;
  logic [SW:0]     sum_r;

  always_comb begin
    case (ch_r)
      2'd0:    ch_eff = 2'd0;
      2'd1:    ch_eff = 2'd1;
      default: ch_eff = 2'd2;   // code 3 runs as stereo
    endcase

    accept = start && (state_r == S_IDLE);

    // loads: the first load after a close restarts the counts
    base           = block_open_r ? loaded_r : '0;
    out_frames_nxt = block_open_r ? out_frames_r : '0;
    room           = (base < LW'(MAX_INPUT_FRAMES));
    loaded_nxt     = room ? base + LW'(1) : base;
    mem_we         = accept && (in_data.kind == lifr_pkg::KIND_LOAD) && room;
    wr_word        = {in_data.right_sample, in_data.left_sample};

    // close: round(loaded * target / source)
    close_zero = (ch_eff == 2'd0) || (src_r == '0) || (tgt_r == '0) || (loaded_nxt == '0);
    cprod      = CLW'(loaded_nxt) * CLW'(tgt_r);
    close_dvd  = DVW'(cprod) + DVW'(src_r[RW-1:1]);

    // reads
    rd_idx     = in_data.read_index;
    rd_ok      = (CW'(rd_idx) < CW'(out_frames_r)) && (loaded_r != '0) && (ch_eff != 2'd0);
    frames_m1  = AW'(loaded_r - LW'(1));
    eq_first   = (CW'(rd_idx) < CW'(loaded_r)) ? AW'(rd_idx) : frames_m1;
    one_second = (loaded_r > LW'(1)) ? AW'(1) : '0;
    rprod      = RPW'(rd_idx) * RPW'(frames_m1);
    read_dvd   = DVW'({rprod, {FW{1'b0}}});

    // restoring divider step
    shifted = {rem_r, quo_r[DVW-1]};
    trial   = shifted - {1'b0, div_r};
    q_bit   = !trial[DSW];

    // output frame count clamped to the capacity
    if (ch_eff == 2'd2) begin
      clamp_n = (quo_r > DVW'(OUT_SAMPLE_CAP / 2)) ? DVW'(OUT_SAMPLE_CAP / 2) : quo_r;
    end else begin
      clamp_n = (quo_r > DVW'(OUT_SAMPLE_CAP)) ? DVW'(OUT_SAMPLE_CAP) : quo_r;
    end
    clamp_frames = OW'(clamp_n);

    // PIW.16 position (24.16 at the defaults) into the two neighbor frames
    pos_int    = quo_r[DVW-1:FW];
    pos_first  = (pos_int > PIW'(frames_m1)) ? frames_m1 : AW'(pos_int);
    pos_second = ((LW'(pos_first) + LW'(1)) < loaded_r) ? pos_first + AW'(1) : pos_first;

    // lerp
    diff_l = $signed({rd_b_r[SW-1], rd_b_r[SW-1:0]}) - $signed({rd_a_r[SW-1], rd_a_r[SW-1:0]});
    diff_r = $signed({rd_b_r[2*SW-1], rd_b_r[2*SW-1:SW]})
           - $signed({rd_a_r[2*SW-1], rd_a_r[2*SW-1:SW]});
    frac_s = $signed({1'b0, frac_r});
    sum_l  = {a_l_r[SW-1], a_l_r} + prod_l_r[SW+FW:FW];
    sum_r  = {a_r_r[SW-1], a_r_r} + prod_r_r[SW+FW:FW];
  end

  // ---------------------------------------------------------------------------
  // Frame store: one write port, two registered read ports
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[AW'(base)] <= wr_word;
    end
    rd_a_r <= frame_mem[addr_a_r];
    rd_b_r <= frame_mem[addr_b_r];
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      loaded_r     <= '0;
      out_frames_r <= '0;
      block_open_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept && (in_data.kind == lifr_pkg::KIND_LOAD)) begin
            loaded_r     <= loaded_nxt;
            block_open_r <= !in_data.last_frame;
            if (in_data.last_frame && !close_zero) begin
              op_close_r <= 1'b1;
              quo_r      <= close_dvd;
              rem_r      <= '0;
              div_r      <= DSW'(src_r);
              cnt_r      <= CNW'(DVW);
              state_r    <= S_DIV;
            end else begin
              // plain load beat, or a close that yields no output frames
              out_frames_r            <= in_data.last_frame ? '0 : out_frames_nxt;
              out_valid_r             <= 1'b1;
              out_data_r.sample_total <= in_data.last_frame ? '0 :
                                         total_of(out_frames_nxt, ch_eff);
              out_data_r.left_out     <= '0;
              out_data_r.right_out    <= '0;
              out_data_r.index_ok     <= 1'b0;
            end
          end else if (accept) begin
            if (!rd_ok) begin
              out_valid_r             <= 1'b1;
              out_data_r.sample_total <= total_of(out_frames_r, ch_eff);
              out_data_r.left_out     <= '0;
              out_data_r.right_out    <= '0;
              out_data_r.index_ok     <= 1'b0;
            end else if (src_r == tgt_r) begin
              addr_a_r <= eq_first;
              addr_b_r <= eq_first;
              frac_r   <= '0;
              state_r  <= S_RD;
            end else if (out_frames_r > OW'(1)) begin
              op_close_r <= 1'b0;
              quo_r      <= read_dvd;
              rem_r      <= '0;
              div_r      <= DSW'(out_frames_r - OW'(1));
              cnt_r      <= CNW'(DVW);
              state_r    <= S_DIV;
            end else begin
              // single output frame: position zero
              addr_a_r <= '0;
              addr_b_r <= one_second;
              frac_r   <= '0;
              state_r  <= S_RD;
            end
          end
        end
        S_DIV: begin
          rem_r <= q_bit ? trial[DSW-1:0] : shifted[DSW-1:0];
          quo_r <= {quo_r[DVW-2:0], q_bit};
          cnt_r <= cnt_r - CNW'(1);
          if (cnt_r == CNW'(1)) begin
            state_r <= S_POS;
          end
        end
        S_POS: begin
          if (op_close_r) begin
            out_frames_r            <= clamp_frames;
            out_valid_r             <= 1'b1;
            out_data_r.sample_total <= total_of(clamp_frames, ch_eff);
            out_data_r.left_out     <= '0;
            out_data_r.right_out    <= '0;
            out_data_r.index_ok     <= 1'b0;
            state_r                 <= S_IDLE;
          end else begin
            addr_a_r <= pos_first;
            addr_b_r <= pos_second;
            frac_r   <= quo_r[FW-1:0];
            state_r  <= S_RD;
          end
        end
        S_RD: begin
          // store read in flight
          state_r <= S_MUL;
        end
        S_MUL: begin
          a_l_r    <= $signed(rd_a_r[SW-1:0]);
          a_r_r    <= $signed(rd_a_r[2*SW-1:SW]);
          prod_l_r <= (2*SW+2)'(diff_l) * (2*SW+2)'(frac_s);
          prod_r_r <= (2*SW+2)'(diff_r) * (2*SW+2)'(frac_s);
          state_r  <= S_ADD;
        end
        S_ADD: begin
          out_valid_r             <= 1'b1;
          out_data_r.sample_total <= total_of(out_frames_r, ch_eff);
          out_data_r.left_out     <= $signed(sum_l[SW-1:0]);
          out_data_r.right_out    <= (ch_eff == 2'd2) ? $signed(sum_r[SW-1:0]) : '0;
          out_data_r.index_ok     <= 1'b1;
          state_r                 <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_loaded_bound: assert property (@(posedge clk) disable iff (!rst_n)
    loaded_r <= LW'(MAX_INPUT_FRAMES))
    else $error("loaded frame count beyond store depth");

  a_open_no_frames: assert property (@(posedge clk) disable iff (!rst_n)
    block_open_r |-> (out_frames_r == '0))
    else $error("open block has output frames");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < div_r))
    else $error("divider remainder not below divisor");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == S_IDLE))
    else $error("result strobe while sequencer busy");

  a_ok_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.index_ok) |-> (!block_open_r && (loaded_r != '0)))
    else $error("valid read result from open or empty block");

endmodule

`default_nettype wire
